### sv/ifsc_pkg.sv
// shared types, codes and constants of the fall state classifier
package ifsc_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int LIMIT_W   = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_NUM   = 8;

	// angles in 1/4096 rad, slopes in Q16
	localparam int ONE_DEG    = 71;
	localparam int DIR_MARGIN = 819;
	localparam int SLOPE_HALF = 35802;
	localparam int SLOPE_BACK = 48957;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STAGGER_X      = 3'd0,
		REG_STAGGER_Y      = 3'd1,
		REG_STAGGER_KICK_X = 3'd2,
		REG_STAGGER_KICK_Y = 3'd3,
		REG_FALL_X         = 3'd4,
		REG_FALL_Y         = 3'd5,
		REG_FALL_KICK_X    = 3'd6,
		REG_FALL_KICK_Y    = 3'd7
	} cfg_reg_t;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET [CFG_NUM] = '{
		13'd1434, 13'd1434, 13'd1843, 13'd1843,
		13'd2867, 13'd2867, 13'd3277, 13'd3277
	};

	localparam logic [2:0] DIR_NONE  = 3'd0;
	localparam logic [2:0] DIR_FRONT = 3'd1;
	localparam logic [2:0] DIR_LEFT  = 3'd2;
	localparam logic [2:0] DIR_BACK  = 3'd3;
	localparam logic [2:0] DIR_RIGHT = 3'd4;

	localparam logic [1:0] SIDE_NONE   = 2'd0;
	localparam logic [1:0] SIDE_LEFT   = 2'd1;
	localparam logic [1:0] SIDE_RIGHT  = 2'd2;
	localparam logic [1:0] SIDE_FALLEN = 2'd3;

	localparam logic [1:0] MOT_OTHER = 2'd0;
	localparam logic [1:0] MOT_KICK  = 2'd1;
	localparam logic [1:0] MOT_GETUP = 2'd2;
	localparam logic [1:0] MOT_DEAD  = 2'd3;

	localparam logic signed [1:0] ROT_ZERO = 2'sb00;
	localparam logic signed [1:0] ROT_POS  = 2'sb01;
	localparam logic signed [1:0] ROT_NEG  = 2'sb11;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] y;
		logic signed [SAMPLE_W-1:0] z;
	} accel_t;

endpackage

### sv/ifsc_cell.sv
// one window cell: holds a three-axis sample and hands it on at each shift
module ifsc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  ifsc_pkg::accel_t d,
	output ifsc_pkg::accel_t q
);
	import ifsc_pkg::*;

	accel_t sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

### sv/ifsc_window.sv
// moving window of acceleration samples as a chain of cells, with running sums
module ifsc_window #(
	parameter int WINDOW_LEN = 8,
	parameter int SUM_W      = 16 + $clog2(WINDOW_LEN)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    shift,
	input  ifsc_pkg::accel_t         sample,
	output logic signed [SUM_W-1:0] sum_x,
	output logic signed [SUM_W-1:0] sum_y,
	output logic signed [SUM_W-1:0] sum_z
);
	import ifsc_pkg::*;

	accel_t tap [WINDOW_LEN];
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_chain
		if (i == 0) begin : g_head
			ifsc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (sample),
				.q      (tap[i])
			);
		end else begin : g_body
			ifsc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (tap[i-1]),
				.q      (tap[i])
			);
		end
	end

	// new sample in, oldest sample (last cell) out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
		end else if (shift) begin
			sum_x_q <= sum_x_q + SUM_W'(sample.x) - SUM_W'(tap[WINDOW_LEN-1].x);
			sum_y_q <= sum_y_q + SUM_W'(sample.y) - SUM_W'(tap[WINDOW_LEN-1].y);
			sum_z_q <= sum_z_q + SUM_W'(sample.z) - SUM_W'(tap[WINDOW_LEN-1].z);
		end
	end

	assign sum_x = sum_x_q;
	assign sum_y = sum_y_q;
	assign sum_z = sum_z_q;

endmodule

### sv/imu_fall_state_classifier_core.sv
// an accepted input is registered by stage 1, stage 2 and then the output registers
// throughput: one transaction per cycle unless a low out_ready has filled the pipeline
// stages: window shift and tilt tests, window-sum slope tests, state update into outputs
// reset: state undefined, no fall recorded, window and sums zero, limits at defaults
// the pipeline keeps accepting while a result waits, up to its two free stages
module imu_fall_state_classifier_core #(
	parameter int WINDOW_LEN   = 8,
	parameter int FALL_TIME_MS = 1000
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ifsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ifsc_pkg::LIMIT_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [15:0]                accel_x,
	input  logic signed [15:0]                accel_y,
	input  logic signed [15:0]                accel_z,
	input  logic signed [14:0]                tilt_x,
	input  logic signed [14:0]                tilt_y,
	input  logic [1:0]                        motion_kind,
	input  logic [31:0]                       frame_time,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        body_state,
	output logic [2:0]                        fall_direction,
	output logic [1:0]                        side_memory,
	output logic signed [1:0]                 rotation_offset
);
	import ifsc_pkg::*;

	localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
	localparam int PROD_W = SUM_W + 16;

	typedef enum logic [2:0] {
		PH_UPRIGHT = 3'd0,
		PH_STAGGER = 3'd1,
		PH_FALLING = 3'd2,
		PH_GROUND  = 3'd3,
		PH_UNDEF   = 3'd4
	} phase_t;

	typedef struct packed {
		logic        calm;
		logic        stag;
		logic        fall;
		logic [2:0]  dir;
		logic        dead;
		logic        getup;
		logic [31:0] now;
	} tilt_info_t;

	typedef struct packed {
		logic wide_x;
		logic narrow_x;
		logic wide_y;
		logic narrow_y;
	} ground_info_t;

	// configuration
	logic [LIMIT_W-1:0] limit_q [CFG_NUM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_NUM; i++) begin
				limit_q[i] <= LIMIT_RESET[i];
			end
		end else if (cfg_we) begin
			limit_q[cfg_index] <= cfg_data;
		end
	end

	// stage enables
	logic v1_q, v2_q, out_valid_q;
	logic en1, en2, en3, accept;

	assign en3      = !out_valid_q || out_ready;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign in_ready = en1;
	assign accept   = in_valid && en1;

	// stage 1: tilt tests against the selected limits
	logic               kick;
	logic [LIMIT_W-1:0] stx, sty, flx, fly;
	logic [14:0]        ax, ay;
	logic signed [16:0] stx_lo, sty_lo;
	tilt_info_t         t1_d, t1_s1, t1_s2;

	always_comb begin
		kick = motion_kind == MOT_KICK;
		stx  = kick ? limit_q[REG_STAGGER_KICK_X] : limit_q[REG_STAGGER_X];
		sty  = kick ? limit_q[REG_STAGGER_KICK_Y] : limit_q[REG_STAGGER_Y];
		flx  = kick ? limit_q[REG_FALL_KICK_X] : limit_q[REG_FALL_X];
		fly  = kick ? limit_q[REG_FALL_KICK_Y] : limit_q[REG_FALL_Y];
		ax   = tilt_x[14] ? 15'(-tilt_x) : 15'(tilt_x);
		ay   = tilt_y[14] ? 15'(-tilt_y) : 15'(tilt_y);
		// lower hysteresis bound may go negative
		stx_lo = $signed({4'b0, stx}) - 17'(ONE_DEG);
		sty_lo = $signed({4'b0, sty}) - 17'(ONE_DEG);
		t1_d.calm = ($signed({2'b0, ax}) <= stx_lo) && ($signed({2'b0, ay}) <= sty_lo);
		t1_d.stag = ({1'b0, ax} >= 16'(stx) + 16'(ONE_DEG)) ||
			({1'b0, ay} >= 16'(sty) + 16'(ONE_DEG));
		t1_d.fall = (ax >= 15'(flx)) || (ay >= 15'(fly));
		if ({1'b0, ax} > {1'b0, ay} + 16'(DIR_MARGIN)) begin
			t1_d.dir = tilt_x[14] ? DIR_LEFT : DIR_RIGHT;
		end else begin
			t1_d.dir = (!tilt_y[14] && (tilt_y != '0)) ? DIR_FRONT : DIR_BACK;
		end
		t1_d.dead  = motion_kind == MOT_DEAD;
		t1_d.getup = motion_kind == MOT_GETUP;
		t1_d.now   = frame_time;
	end

	accel_t                  sample;
	logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;

	assign sample = '{x: accel_x, y: accel_y, z: accel_z};

	ifsc_window #(
		.WINDOW_LEN (WINDOW_LEN),
		.SUM_W      (SUM_W)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (accept),
		.sample (sample),
		.sum_x  (sum_x),
		.sum_y  (sum_y),
		.sum_z  (sum_z)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			t1_s1 <= t1_d;
		end
	end

	// stage 2: constant-slope tests on the window sums
	logic [SUM_W-1:0]  mag_x, mag_y, mag_z;
	logic [PROD_W-1:0] z_shift, prod_bx, prod_hx, prod_by, prod_hy;
	ground_info_t      g_d, g_s2;

	always_comb begin
		mag_x   = sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
		mag_y   = sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);
		mag_z   = sum_z[SUM_W-1] ? SUM_W'(-sum_z) : SUM_W'(sum_z);
		z_shift = {mag_z, 16'b0};
		prod_bx = PROD_W'(mag_x) * PROD_W'(SLOPE_BACK);
		prod_hx = PROD_W'(mag_x) * PROD_W'(SLOPE_HALF);
		prod_by = PROD_W'(mag_y) * PROD_W'(SLOPE_BACK);
		prod_hy = PROD_W'(mag_y) * PROD_W'(SLOPE_HALF);
		g_d.wide_x   = sum_x[SUM_W-1] && (z_shift < prod_bx);
		g_d.narrow_x = ((sum_x == '0) && (sum_z == '0)) ||
			(!sum_x[SUM_W-1] && (sum_x != '0) && (z_shift < prod_hx));
		g_d.wide_y   = sum_y[SUM_W-1] && (z_shift < prod_by);
		g_d.narrow_y = ((sum_y == '0) && (sum_z == '0)) ||
			(!sum_y[SUM_W-1] && (sum_y != '0) && (z_shift < prod_hy));
	end

	always_ff @(posedge clk) begin
		if (en2 && v1_q) begin
			t1_s2 <= t1_s1;
			g_s2  <= g_d;
		end
	end

	// stage 3: body state update, whose registers are the outputs
	phase_t             phase_q, phase_d;
	logic [2:0]         dir_q, dir_d;
	logic [1:0]         side_q, side_d;
	logic [31:0]        last_fall_q, last_fall_d, diff;
	logic               seen_q, seen_d, hold;
	logic signed [1:0]  rot_q, rot_d;

	function automatic logic [1:0] side_of(input logic [2:0] dir);
		case (dir)
			DIR_LEFT:  side_of = SIDE_LEFT;
			DIR_RIGHT: side_of = SIDE_RIGHT;
			default:   side_of = SIDE_NONE;
		endcase
	endfunction

	always_comb begin
		phase_d     = phase_q;
		dir_d       = dir_q;
		side_d      = side_q;
		last_fall_d = last_fall_q;
		seen_d      = seen_q;
		rot_d       = ROT_ZERO;
		diff        = t1_s2.now - last_fall_q;
		// a timestamp before the last fall counts as inside the hold
		hold        = seen_q && (diff[31] || (diff <= 32'(FALL_TIME_MS)));
		if (t1_s2.dead) begin
			phase_d = PH_UNDEF;
		end else if (hold) begin
			phase_d = PH_FALLING;
		end else if (t1_s2.calm || (phase_q == PH_UPRIGHT && !t1_s2.stag)) begin
			phase_d = PH_UPRIGHT;
			dir_d   = DIR_NONE;
			side_d  = SIDE_NONE;
		end else if (phase_q == PH_STAGGER && t1_s2.fall) begin
			last_fall_d = t1_s2.now;
			seen_d      = 1'b1;
			phase_d     = PH_FALLING;
			dir_d       = t1_s2.dir;
			if (side_q != SIDE_FALLEN) begin
				side_d = side_of(t1_s2.dir);
			end
		end else if (((phase_q == PH_UPRIGHT || phase_q == PH_STAGGER) && t1_s2.stag) ||
				(phase_q == PH_STAGGER && t1_s2.calm)) begin
			phase_d = PH_STAGGER;
			dir_d   = t1_s2.dir;
			if (side_q != SIDE_FALLEN) begin
				side_d = side_of(t1_s2.dir);
			end
		end else begin
			phase_d = PH_UNDEF;
			if (g_s2.wide_x) begin
				dir_d   = DIR_FRONT;
				phase_d = PH_GROUND;
				if (!t1_s2.getup && (side_q == SIDE_LEFT || side_q == SIDE_RIGHT)) begin
					rot_d  = (side_q == SIDE_LEFT) ? ROT_POS : ROT_NEG;
					side_d = SIDE_FALLEN;
				end
			end else if (g_s2.narrow_x) begin
				dir_d   = DIR_BACK;
				phase_d = PH_GROUND;
				if (!t1_s2.getup && (side_q == SIDE_LEFT || side_q == SIDE_RIGHT)) begin
					rot_d  = (side_q == SIDE_LEFT) ? ROT_NEG : ROT_POS;
					side_d = SIDE_FALLEN;
				end
			end else if (g_s2.wide_y) begin
				dir_d   = DIR_LEFT;
				phase_d = PH_GROUND;
				if (!t1_s2.getup && side_q != SIDE_FALLEN) begin
					side_d = SIDE_LEFT;
				end
			end else if (g_s2.narrow_y) begin
				dir_d   = DIR_RIGHT;
				phase_d = PH_GROUND;
				if (!t1_s2.getup && side_q != SIDE_FALLEN) begin
					side_d = SIDE_RIGHT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_UNDEF;
			dir_q       <= DIR_NONE;
			side_q      <= SIDE_NONE;
			last_fall_q <= '0;
			seen_q      <= 1'b0;
			rot_q       <= ROT_ZERO;
		end else begin
			if (en1) begin
				v1_q <= accept;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				out_valid_q <= v2_q;
			end
			if (en3 && v2_q) begin
				phase_q     <= phase_d;
				dir_q       <= dir_d;
				side_q      <= side_d;
				last_fall_q <= last_fall_d;
				seen_q      <= seen_d;
				rot_q       <= rot_d;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign body_state      = phase_q;
	assign fall_direction  = dir_q;
	assign side_memory     = side_q;
	assign rotation_offset = rot_q;

endmodule

### tb/tb_imu_fall_state_classifier_core.sv
// self-checking testbench of the fall state classifier core with its own state predictor
`timescale 1ns / 1ps

module tb_imu_fall_state_classifier_core;
	import ifsc_pkg::*;

	localparam int WIN_LEN      = 8;
	localparam int FALL_HOLD_MS = 1000;
	localparam int TILT_MAX     = 12868;
	localparam int LIMIT_MAX    = 6434;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int STALL_CYCLES = 400;

	localparam logic [2:0] BODY_UPRIGHT = 3'd0;
	localparam logic [2:0] BODY_STAGGER = 3'd1;
	localparam logic [2:0] BODY_FALLING = 3'd2;
	localparam logic [2:0] BODY_GROUND  = 3'd3;
	localparam logic [2:0] BODY_UNDEF   = 3'd4;

	typedef enum int {Z_CALM, Z_BAND, Z_STAG, Z_FALL, Z_ANY} tilt_zone_e;
	typedef enum int {P_UP, P_FRONT, P_BACK, P_LEFT, P_RIGHT, P_ZERO, P_RAND} accel_pose_e;
	typedef enum int {CFG_DEFAULT, CFG_RANDOM, CFG_ZERO, CFG_MAX, CFG_FINE} limit_set_e;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [14:0] tilt_x;
		logic signed [14:0] tilt_y;
		logic [1:0]         motion;
		logic [31:0]        ftime;
	} frame_t;

	typedef struct packed {
		logic [2:0]        body;
		logic [2:0]        dir;
		logic [1:0]        side;
		logic signed [1:0] rot;
	} state_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LIMIT_W-1:0]   cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [15:0]   accel_x = '0;
	logic signed [15:0]   accel_y = '0;
	logic signed [15:0]   accel_z = '0;
	logic signed [14:0]   tilt_x = '0;
	logic signed [14:0]   tilt_y = '0;
	logic [1:0]           motion_kind = MOT_OTHER;
	logic [31:0]          frame_time = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [2:0]           body_state;
	logic [2:0]           fall_direction;
	logic [1:0]           side_memory;
	logic signed [1:0]    rotation_offset;

	imu_fall_state_classifier_core #(
		.WINDOW_LEN  (WIN_LEN),
		.FALL_TIME_MS(FALL_HOLD_MS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.accel_x        (accel_x),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.tilt_x         (tilt_x),
		.tilt_y         (tilt_y),
		.motion_kind    (motion_kind),
		.frame_time     (frame_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.body_state     (body_state),
		.fall_direction (fall_direction),
		.side_memory    (side_memory),
		.rotation_offset(rotation_offset)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [LIMIT_W-1:0] lim [CFG_NUM];
	logic [2:0]         body_now = BODY_UNDEF;
	logic [2:0]         dir_now = DIR_NONE;
	logic [1:0]         side_now = SIDE_NONE;
	logic [31:0]        fall_stamp = '0;
	logic               fall_noted = 1'b0;
	int                 accel_hist [WIN_LEN][3];
	longint             accel_sum [3];
	int                 hist_pos = 0;

	frame_t     frame_q [$];
	state_out_t predicted_q [$];
	frame_t     frame_cur;
	state_out_t due_res;
	logic [31:0] now_ms = '0;
	int         n_queued = 0;
	int         n_accepted = 0;
	int         n_errors = 0;
	int         cycle_cnt = 0;
	int         stall_ticket = 0;
	int         stall_served = 0;
	int         hold_left = 0;
	logic       steady = 1'b0;

	function automatic int pick(int lo, int hi);
		if (hi < lo)
			hi = lo;
		return lo + int'($urandom_range(hi - lo, 0));
	endfunction

	// |atan2(b, a)| > 2.5 as a slope test
	function automatic logic beyond_back(longint a, longint b);
		longint m;
		m = (b < 0) ? -b : b;
		return (a < 0) && (m * 65536 < longint'(SLOPE_BACK) * (-a));
	endfunction

	// |atan2(b, a)| < 0.5, with the all-zero vector counted in
	function automatic logic near_axis(longint a, longint b);
		longint m;
		m = (b < 0) ? -b : b;
		if (a == 0 && b == 0)
			return 1'b1;
		return (a > 0) && (m * 65536 < longint'(SLOPE_HALF) * a);
	endfunction

	function automatic logic [2:0] tilt_direction(int tx, int ty, int ax, int ay);
		if (ax > ay + DIR_MARGIN)
			return (tx < 0) ? DIR_LEFT : DIR_RIGHT;
		return (ty > 0) ? DIR_FRONT : DIR_BACK;
	endfunction

	function automatic logic [1:0] side_from_dir(logic [2:0] d);
		if (d == DIR_LEFT)
			return SIDE_LEFT;
		if (d == DIR_RIGHT)
			return SIDE_RIGHT;
		return SIDE_NONE;
	endfunction

	function automatic state_out_t classify_frame(frame_t f);
		int tx, ty, ax, ay, stx, sty, flx, fly;
		int s [3];
		logic [31:0] diff;
		logic kick, calm, stag, fall, hold, getup;
		logic signed [1:0] rot;
		state_out_t r;
		tx = f.tilt_x;
		ty = f.tilt_y;
		ax = (tx < 0) ? -tx : tx;
		ay = (ty < 0) ? -ty : ty;
		s[0] = f.accel_x;
		s[1] = f.accel_y;
		s[2] = f.accel_z;
		for (int k = 0; k < 3; k++) begin
			accel_sum[k] += s[k] - accel_hist[hist_pos][k];
			accel_hist[hist_pos][k] = s[k];
		end
		hist_pos = (hist_pos + 1) % WIN_LEN;

		kick = f.motion == MOT_KICK;
		stx = kick ? lim[REG_STAGGER_KICK_X] : lim[REG_STAGGER_X];
		sty = kick ? lim[REG_STAGGER_KICK_Y] : lim[REG_STAGGER_Y];
		flx = kick ? lim[REG_FALL_KICK_X] : lim[REG_FALL_X];
		fly = kick ? lim[REG_FALL_KICK_Y] : lim[REG_FALL_Y];
		calm = (ax <= stx - ONE_DEG) && (ay <= sty - ONE_DEG);
		stag = (ax >= stx + ONE_DEG) || (ay >= sty + ONE_DEG);
		fall = (ax >= flx) || (ay >= fly);
		rot = ROT_ZERO;

		if (f.motion == MOT_DEAD) begin
			body_now = BODY_UNDEF;
		end else begin
			diff = f.ftime - fall_stamp;
			hold = fall_noted && (diff[31] || diff <= FALL_HOLD_MS);
			if (hold) begin
				body_now = BODY_FALLING;
			end else if (calm || (body_now == BODY_UPRIGHT && !stag)) begin
				body_now = BODY_UPRIGHT;
				dir_now = DIR_NONE;
				side_now = SIDE_NONE;
			end else if (body_now == BODY_STAGGER && fall) begin
				fall_stamp = f.ftime;
				fall_noted = 1'b1;
				body_now = BODY_FALLING;
				dir_now = tilt_direction(tx, ty, ax, ay);
				if (side_now != SIDE_FALLEN)
					side_now = side_from_dir(dir_now);
			end else if (((body_now == BODY_UPRIGHT || body_now == BODY_STAGGER) && stag) ||
					(body_now == BODY_STAGGER && calm)) begin
				body_now = BODY_STAGGER;
				dir_now = tilt_direction(tx, ty, ax, ay);
				if (side_now != SIDE_FALLEN)
					side_now = side_from_dir(dir_now);
			end else begin
				// lying pose from the window sums
				getup = f.motion == MOT_GETUP;
				body_now = BODY_UNDEF;
				if (beyond_back(accel_sum[0], accel_sum[2])) begin
					dir_now = DIR_FRONT;
					body_now = BODY_GROUND;
					if (!getup && (side_now == SIDE_LEFT || side_now == SIDE_RIGHT)) begin
						rot = (side_now == SIDE_LEFT) ? ROT_POS : ROT_NEG;
						side_now = SIDE_FALLEN;
					end
				end else if (near_axis(accel_sum[0], accel_sum[2])) begin
					dir_now = DIR_BACK;
					body_now = BODY_GROUND;
					if (!getup && (side_now == SIDE_LEFT || side_now == SIDE_RIGHT)) begin
						rot = (side_now == SIDE_LEFT) ? ROT_NEG : ROT_POS;
						side_now = SIDE_FALLEN;
					end
				end else if (beyond_back(accel_sum[1], accel_sum[2])) begin
					dir_now = DIR_LEFT;
					body_now = BODY_GROUND;
					if (!getup && side_now != SIDE_FALLEN)
						side_now = SIDE_LEFT;
				end else if (near_axis(accel_sum[1], accel_sum[2])) begin
					dir_now = DIR_RIGHT;
					body_now = BODY_GROUND;
					if (!getup && side_now != SIDE_FALLEN)
						side_now = SIDE_RIGHT;
				end
			end
		end
		r.body = body_now;
		r.dir = dir_now;
		r.side = side_now;
		r.rot = rot;
		return r;
	endfunction

	task automatic push_frame(int ax, int ay, int az, int tx, int ty, logic [1:0] mot, int dt);
		frame_t f;
		now_ms = now_ms + dt;
		f.accel_x = 16'(ax);
		f.accel_y = 16'(ay);
		f.accel_z = 16'(az);
		f.tilt_x = 15'(tx);
		f.tilt_y = 15'(ty);
		f.motion = mot;
		f.ftime = now_ms;
		frame_q.push_back(f);
		n_queued++;
	endtask

	// tilt magnitude inside a band around the active limits of one axis
	function automatic int zone_mag(tilt_zone_e zone, int s_lim, int f_lim);
		int r;
		case (zone)
			Z_CALM: r = (pick(0, 7) == 0) ? s_lim - ONE_DEG : pick(0, s_lim - ONE_DEG - 1);
			Z_BAND: begin
				if (pick(0, 3) == 0)
					r = pick(0, 1) ? s_lim - ONE_DEG : s_lim + ONE_DEG;
				else
					r = pick(s_lim - ONE_DEG, s_lim + ONE_DEG);
			end
			Z_STAG: r = pick(s_lim + ONE_DEG, f_lim - 1);
			Z_FALL: r = (pick(0, 5) == 0) ? f_lim : pick(f_lim, TILT_MAX);
			default: r = pick(0, TILT_MAX);
		endcase
		if (r < 0)
			r = 0;
		if (r > TILT_MAX)
			r = TILT_MAX;
		return r;
	endfunction

	function automatic logic [1:0] some_motion();
		int r;
		r = pick(0, 99);
		if (r < 68)
			return MOT_OTHER;
		if (r < 88)
			return MOT_KICK;
		if (r < 95)
			return MOT_GETUP;
		return MOT_DEAD;
	endfunction

	task automatic gen_frame(tilt_zone_e zone, accel_pose_e pose, logic [1:0] mot, int dt);
		int sx_l, sy_l, fx_l, fy_l, p, q, ax, ay, az;
		logic kick;
		kick = mot == MOT_KICK;
		sx_l = kick ? lim[REG_STAGGER_KICK_X] : lim[REG_STAGGER_X];
		sy_l = kick ? lim[REG_STAGGER_KICK_Y] : lim[REG_STAGGER_Y];
		fx_l = kick ? lim[REG_FALL_KICK_X] : lim[REG_FALL_X];
		fy_l = kick ? lim[REG_FALL_KICK_Y] : lim[REG_FALL_Y];
		if (zone == Z_CALM) begin
			p = zone_mag(Z_CALM, sx_l, fx_l);
			q = zone_mag(Z_CALM, sy_l, fy_l);
		end else if (pick(0, 1) == 1) begin
			p = zone_mag(zone, sx_l, fx_l);
			q = pick(0, p / 4);
		end else begin
			q = zone_mag(zone, sy_l, fy_l);
			p = pick(0, q / 4);
		end
		if (pick(0, 1) == 1)
			p = -p;
		if (pick(0, 1) == 1)
			q = -q;
		case (pose)
			P_UP: begin
				ax = pick(-300, 300);
				ay = pick(-300, 300);
				az = pick(3000, 5000);
			end
			P_FRONT: begin
				ax = -pick(3000, 5000);
				ay = pick(-300, 300);
				az = pick(-800, 800);
			end
			P_BACK: begin
				ax = pick(3000, 5000);
				ay = pick(-300, 300);
				az = pick(-800, 800);
			end
			P_LEFT: begin
				ax = pick(-40, 40);
				ay = -pick(3000, 5000);
				az = pick(0, 1) ? pick(1500, 2500) : -pick(1500, 2500);
			end
			P_RIGHT: begin
				ax = pick(-40, 40);
				ay = pick(3000, 5000);
				az = pick(0, 1) ? pick(1500, 2500) : -pick(1500, 2500);
			end
			P_ZERO: begin
				ax = 0;
				ay = 0;
				az = 0;
			end
			default: begin
				ax = pick(0, 65535) - 32768;
				ay = pick(0, 65535) - 32768;
				az = pick(0, 65535) - 32768;
			end
		endcase
		push_frame(ax, ay, az, p, q, mot, dt);
	endtask

	// upright, staggering, fall, hold, lying, getting up, upright again
	task automatic queue_fall_story();
		accel_pose_e lying;
		logic [1:0] mot;
		lying = accel_pose_e'(pick(P_UP, P_RAND));
		repeat (pick(2, 5)) gen_frame(Z_CALM, P_UP, some_motion(), pick(5, 40));
		repeat (pick(1, 4)) gen_frame((pick(0, 2) == 0) ? Z_BAND : Z_STAG, P_UP,
			some_motion(), pick(5, 40));
		mot = (pick(0, 3) == 0) ? MOT_KICK : MOT_OTHER;
		gen_frame(Z_FALL, P_UP, mot, pick(5, 40));
		repeat (pick(3, 10)) gen_frame(pick(0, 1) ? Z_FALL : Z_STAG, lying, MOT_OTHER,
			pick(60, 200));
		repeat (pick(6, 14)) begin
			mot = (pick(0, 4) == 0) ? MOT_GETUP : MOT_OTHER;
			gen_frame(tilt_zone_e'(pick(Z_BAND, Z_FALL)), lying, mot, pick(100, 400));
		end
		repeat (pick(1, 3)) gen_frame(Z_BAND, P_UP, MOT_GETUP, pick(20, 100));
		repeat (pick(1, 3)) gen_frame(Z_CALM, P_UP, MOT_OTHER, pick(20, 100));
	endtask

	task automatic queue_noise();
		repeat (pick(1, 4)) begin
			case (pick(0, 3))
				0: now_ms = $urandom;
				1: now_ms = now_ms - pick(0, 2000);
				default: now_ms = now_ms + pick(0, 300);
			endcase
			push_frame(pick(0, 65535) - 32768, pick(0, 65535) - 32768,
				pick(0, 65535) - 32768, pick(-TILT_MAX, TILT_MAX),
				pick(-TILT_MAX, TILT_MAX), 2'(pick(0, 3)), 0);
		end
	endtask

	task automatic directed_frames();
		now_ms = 32'd100;
		push_frame(0, 0, 0, 0, 0, MOT_OTHER, 0);
		push_frame(32767, 32767, 32767, 1363, 1363, MOT_OTHER, 10);
		// hysteresis band keeps upright
		push_frame(-32768, -32768, -32768, 1364, -1364, MOT_OTHER, 10);
		push_frame(0, 0, 4096, 1505, 0, MOT_OTHER, 10);
		push_frame(0, 0, 4096, 0, 1914, MOT_KICK, 10);
		push_frame(0, 0, 4096, -2867, 0, MOT_OTHER, 10);
		push_frame(0, 0, 4096, 0, 0, MOT_DEAD, 10);
		push_frame(-4000, 0, 0, 3000, 0, MOT_OTHER, 500);
		// timestamp behind the recorded fall
		now_ms = now_ms - 32'd3000;
		push_frame(-4000, 0, 0, 3000, 0, MOT_OTHER, 0);
		push_frame(-4000, 0, 0, 3000, 0, MOT_OTHER, 5000);
		repeat (4) push_frame(-4000, 0, 0, 3000, 0, MOT_OTHER, 20);
		push_frame(-4000, 0, 0, 3000, 0, MOT_GETUP, 20);
		repeat (4) push_frame(0, -4000, 2000, 0, 3000, MOT_OTHER, 20);
		push_frame(0, 0, 4096, 0, 0, MOT_OTHER, 20);
		// fall recorded just before the timestamp wraps
		now_ms = 32'hFFFF_FF00;
		push_frame(0, 0, 4096, 0, 2000, MOT_OTHER, 0);
		push_frame(0, 0, 4096, 0, TILT_MAX, MOT_OTHER, 'h80);
		push_frame(32767, -32768, 0, -TILT_MAX, -TILT_MAX, MOT_OTHER, 'h100);
	endtask

	task automatic load_limits(limit_set_e setting);
		logic [LIMIT_W-1:0] v;
		for (int r = 0; r < CFG_NUM; r++) begin
			case (setting)
				CFG_RANDOM: v = LIMIT_W'(pick(0, LIMIT_MAX));
				CFG_ZERO: v = '0;
				CFG_MAX: v = LIMIT_W'(LIMIT_MAX);
				CFG_FINE: v = LIMIT_W'((r < REG_FALL_X) ? pick(0, 140) : pick(150, 1500));
				default: v = LIMIT_RESET[r];
			endcase
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_t'(r);
			cfg_data <= v;
			lim[r] = v;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (n_accepted != n_queued || predicted_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predicted_q.push_back(classify_frame(frame_cur));
			n_accepted++;
		end
		if (!in_valid || in_ready) begin
			if (frame_q.size() != 0 && (steady || $urandom_range(99, 0) >= 33)) begin
				frame_cur = frame_q.pop_front();
				in_valid <= 1'b1;
				accel_x <= frame_cur.accel_x;
				accel_y <= frame_cur.accel_y;
				accel_z <= frame_cur.accel_z;
				tilt_x <= frame_cur.tilt_x;
				tilt_y <= frame_cur.tilt_y;
				motion_kind <= frame_cur.motion;
				frame_time <= frame_cur.ftime;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (predicted_q.size() == 0) begin
				$error("result transaction with no frame awaiting it");
				n_errors++;
			end else begin
				due_res = predicted_q.pop_front();
				if (body_state !== due_res.body) begin
					$error("body_state: expected %0d, got %0d", due_res.body, body_state);
					n_errors++;
				end
				if (fall_direction !== due_res.dir) begin
					$error("fall_direction: expected %0d, got %0d", due_res.dir, fall_direction);
					n_errors++;
				end
				if (side_memory !== due_res.side) begin
					$error("side_memory: expected %0d, got %0d", due_res.side, side_memory);
					n_errors++;
				end
				if (rotation_offset !== due_res.rot) begin
					$error("rotation_offset: expected %0d, got %0d", due_res.rot,
						rotation_offset);
					n_errors++;
				end
			end
		end
		if (stall_ticket != stall_served) begin
			stall_served = stall_ticket;
			hold_left = STALL_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99, 0) >= 33);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		limit_set_e plan [7];
		int goal;
		plan = '{CFG_DEFAULT, CFG_RANDOM, CFG_ZERO, CFG_MAX, CFG_FINE, CFG_RANDOM, CFG_DEFAULT};
		foreach (lim[i])
			lim[i] = LIMIT_RESET[i];
		foreach (accel_hist[i, k])
			accel_hist[i][k] = 0;
		foreach (accel_sum[k])
			accel_sum[k] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 7; ph++) begin
			// limits at their reset values in the first phase
			if (ph != 0)
				load_limits(plan[ph]);
			steady = (ph == 5);
			if (ph == 0)
				directed_frames();
			goal = n_queued + 104;
			while (n_queued < goal) begin
				if (pick(0, 99) < 80)
					queue_fall_story();
				else
					queue_noise();
			end
			if (ph == 1)
				stall_ticket++;
			drain();
		end
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
